// ===== rtl/lkvc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_pkg: shared types and constants for the LRU key/value cache
// Holds the word structs of both channels, the command codes and the
// sequencer states.
// ----------------------------------------------------------------------------
package lkvc_pkg;

   localparam int ENTRIES_DEF    = 512;
   localparam int KEY_BITS_DEF   = 64;
   localparam int VALUE_BITS_DEF = 32;
   localparam int CAP_BITS       = 10;
   localparam logic [CAP_BITS-1:0] CAP_RESET = 10'd512;

   typedef enum logic {
      CMD_GET = 1'b0,
      CMD_PUT = 1'b1
   } cmd_type;

   typedef struct packed {
      logic        command;
      logic [63:0] key;
      logic [31:0] value;
   } req_word_type;

   typedef struct packed {
      logic        hit;
      logic [31:0] value_out;
      logic        evicted;
      logic [63:0] evicted_key;
   } rsp_word_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CHECK,
      ST_DECIDE,
      ST_PROMO_RD,
      ST_PROMO_FIX,
      ST_EVICT_RD,
      ST_WRITE,
      ST_LINK,
      ST_DONE
   } state_type;

endpackage

// ===== rtl/lru_key_value_cache_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_core: fully associative key/value cache, LRU eviction
// One sequencer walks the stored keys with a single shared comparator and
// then repairs the doubly linked recency list held in small memories.
// ----------------------------------------------------------------------------
// Usage notes.
// A request word (command, key, value) enters on req_valid while req_stall is
// low. The block then raises req_stall until its single response word has
// been taken, so one word is in flight at a time.
// A lookup compares one stored key per cycle through one shared comparator,
// so the time from one acceptance to the next grows with the number of
// stored keys, and an empty cache skips the scan. The scan over the key
// memory, one read port per cycle, sets that cost.
// A get that hits returns the stored value and promotes the entry; a put
// updates or inserts, evicting the least recent entry when the count has
// reached the capacity limit (zero counts as one, large values saturate).
// The response sits in an output register until rsp_stall is low; the block
// holds there and takes no new request meanwhile.
// Reset empties the cache at once (count zero) and sets the capacity limit
// to 512; the entry memories need no clearing pass since only slots below
// the count are ever read. Write csr_capacity_limit only while idle.
// ----------------------------------------------------------------------------
module lru_key_value_cache_core #(
   parameter int ENTRIES    = lkvc_pkg::ENTRIES_DEF,
   parameter int KEY_BITS   = lkvc_pkg::KEY_BITS_DEF,
   parameter int VALUE_BITS = lkvc_pkg::VALUE_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  lkvc_pkg::req_word_type         req_word,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output lkvc_pkg::rsp_word_type         rsp_word,
   input  logic                           csr_write,
   input  logic [lkvc_pkg::CAP_BITS-1:0]  csr_capacity_limit
);
   import lkvc_pkg::*;

   localparam int SW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);

   // Entry memories, one read and one write per cycle each.
   logic [KEY_BITS-1:0]   key_mem   [ENTRIES];
   logic [VALUE_BITS-1:0] val_mem   [ENTRIES];
   logic [SW-1:0]         newer_mem [ENTRIES];
   logic [SW-1:0]         older_mem [ENTRIES];

   state_type state_ff, state_in;
   logic [CAP_BITS-1:0]   cap_ff;
   logic [CW-1:0]         count_ff, count_in;
   logic [SW-1:0]         newest_ff, newest_in, oldest_ff, oldest_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic                  found_ff, found_in;
   logic [SW-1:0]         slot_ff, slot_in;
   logic                  cmd_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] value_ff;
   rsp_word_type          rsp_ff, rsp_in;
   logic                  evict_ff, evict_in;
   logic [SW-1:0]         nw_ff, od_ff;

   // Registered read data.
   logic [KEY_BITS-1:0]   key_rd_ff;
   logic [VALUE_BITS-1:0] val_rd_ff;
   logic [SW-1:0]         newer_rd_ff, older_rd_ff;

   // Memory control.
   logic [SW-1:0]         key_raddr, link_raddr;
   logic                  key_we, val_we, newer_we, older_we;
   logic [SW-1:0]         kv_waddr, newer_waddr, older_waddr;
   logic [SW-1:0]         newer_wdata, older_wdata;

   // Effective capacity: zero counts as one, saturate at ENTRIES.
   logic [CW-1:0] cap_eff;
   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = CW'(1);
      end else if (32'(cap_ff) > 32'(ENTRIES)) begin
         cap_eff = CW'(ENTRIES);
      end else begin
         cap_eff = CW'(cap_ff);
      end
   end

   logic full;
   assign full = (count_ff >= cap_eff);

   // Memories.
   always_ff @(posedge clock) begin
      key_rd_ff   <= key_mem[key_raddr];
      val_rd_ff   <= val_mem[key_raddr];
      newer_rd_ff <= newer_mem[link_raddr];
      older_rd_ff <= older_mem[link_raddr];
      if (key_we) begin
         key_mem[kv_waddr] <= key_ff;
      end
      if (val_we) begin
         val_mem[kv_waddr] <= value_ff;
      end
      if (newer_we) begin
         newer_mem[newer_waddr] <= newer_wdata;
      end
      if (older_we) begin
         older_mem[older_waddr] <= older_wdata;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (count_ff == '0) ? ST_DECIDE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (key_rd_ff == key_ff || idx_ff == count_ff) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (found_ff) begin
               state_in = ST_PROMO_RD;
            end else if (cmd_ff == CMD_GET) begin
               state_in = ST_DONE;
            end else if (full) begin
               state_in = ST_EVICT_RD;
            end else begin
               state_in = ST_WRITE;
            end
         end
         ST_PROMO_RD:  state_in = ST_PROMO_FIX;
         ST_PROMO_FIX: state_in = ST_LINK;
         ST_EVICT_RD:  state_in = ST_WRITE;
         ST_WRITE:     state_in = ST_LINK;
         ST_LINK:      state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs and datapath.
   always_comb begin
      count_in    = count_ff;
      newest_in   = newest_ff;
      oldest_in   = oldest_ff;
      idx_in      = idx_ff;
      found_in    = found_ff;
      slot_in     = slot_ff;
      rsp_in      = rsp_ff;
      evict_in    = evict_ff;
      key_raddr   = idx_ff[SW-1:0];
      link_raddr  = slot_ff;
      key_we      = 1'b0;
      val_we      = 1'b0;
      newer_we    = 1'b0;
      older_we    = 1'b0;
      kv_waddr    = slot_ff;
      newer_waddr = slot_ff;
      older_waddr = slot_ff;
      newer_wdata = slot_ff;
      older_wdata = slot_ff;
      case (state_ff)
         ST_IDLE: begin
            idx_in   = '0;
            found_in = 1'b0;
            evict_in = 1'b0;
            rsp_in   = '0;
            key_raddr = '0;
         end
         ST_SCAN: begin
            // Address of slot idx is issued; idx then points to the next one.
            key_raddr = idx_ff[SW-1:0];
            idx_in    = idx_ff + CW'(1);
         end
         ST_CHECK: begin
            key_raddr = idx_ff[SW-1:0];
            if (key_rd_ff == key_ff) begin
               found_in = 1'b1;
               slot_in  = SW'(idx_ff - CW'(1));
            end else if (idx_ff != count_ff) begin
               idx_in = idx_ff + CW'(1);
            end
         end
         ST_DECIDE: begin
            key_raddr  = slot_ff;
            link_raddr = slot_ff;
            if (found_ff) begin
               rsp_in.hit = 1'b1;
               if (cmd_ff == CMD_PUT) begin
                  val_we = 1'b1;
               end
            end else if (cmd_ff == CMD_PUT) begin
               if (full) begin
                  slot_in    = oldest_ff;
                  key_raddr  = oldest_ff;
                  link_raddr = oldest_ff;
                  evict_in   = 1'b1;
               end else begin
                  slot_in = SW'(count_ff);
               end
            end
         end
         ST_PROMO_RD: begin
            // Value and links of the hit slot are now in the read registers.
            if (cmd_ff == CMD_GET) begin
               rsp_in.value_out = 32'(val_rd_ff);
            end
         end
         ST_PROMO_FIX: begin
            if (slot_ff != newest_ff) begin
               // Unlink: older_link[nw] = od; the slot is not newest, so nw
               // is a valid slot.
               older_we    = 1'b1;
               older_waddr = nw_ff;
               older_wdata = od_ff;
               if (slot_ff == oldest_ff) begin
                  oldest_in = nw_ff;
               end else begin
                  newer_we    = 1'b1;
                  newer_waddr = od_ff;
                  newer_wdata = nw_ff;
               end
            end
         end
         ST_EVICT_RD: begin
            rsp_in.evicted     = 1'b1;
            rsp_in.evicted_key = 64'(key_rd_ff);
         end
         ST_WRITE: begin
            key_we = 1'b1;
            val_we = 1'b1;
            if (evict_ff) begin
               if (count_ff <= CW'(1)) begin
                  newest_in = slot_ff;
                  oldest_in = slot_ff;
               end else begin
                  oldest_in = nw_ff;
               end
            end else begin
               count_in = count_ff + CW'(1);
               if (count_ff == '0) begin
                  newest_in = slot_ff;
                  oldest_in = slot_ff;
               end
            end
         end
         ST_LINK: begin
            // Push the slot at the newest end unless it already is there.
            if (slot_ff != newest_ff) begin
               older_we    = 1'b1;
               older_waddr = slot_ff;
               older_wdata = newest_ff;
               newer_we    = 1'b1;
               newer_waddr = newest_ff;
               newer_wdata = slot_ff;
               newest_in   = slot_ff;
            end
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);
   assign rsp_word  = rsp_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cap_ff    <= CAP_RESET;
         count_ff  <= '0;
         newest_ff <= '0;
         oldest_ff <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         newest_ff <= newest_in;
         oldest_ff <= oldest_in;
         if (csr_write) begin
            cap_ff <= csr_capacity_limit;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      found_ff <= found_in;
      slot_ff  <= slot_in;
      rsp_ff   <= rsp_in;
      evict_ff <= evict_in;
      if (state_ff == ST_PROMO_RD || state_ff == ST_EVICT_RD) begin
         nw_ff <= newer_rd_ff;
         od_ff <= older_rd_ff;
      end
      if (state_ff == ST_IDLE && req_valid) begin
         cmd_ff   <= req_word.command;
         key_ff   <= KEY_BITS'(req_word.key);
         value_ff <= VALUE_BITS'(req_word.value);
      end
   end

endmodule

// ===== sim/tb_lru_key_value_cache_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache_core: self-checking bench for the LRU key/value cache
// Drives get and put words through the valid/stall request channel, predicts
// every response word with a behavioral LRU list kept in the bench, and
// compares each response field by field. Several capacity settings are used,
// with random idling on both channels and stretches of back-pressure.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache_core;
   import lkvc_pkg::*;

   localparam int DEPTH        = ENTRIES_DEF;
   localparam int IDLE_LIMIT   = 20000;
   localparam int HOLD_CYCLES  = 3000;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_word;
   logic         csr_write;
   logic [CAP_BITS-1:0] csr_capacity_limit;

   lru_key_value_cache_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
      .csr_write(csr_write), .csr_capacity_limit(csr_capacity_limit)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // ------------------------------------------------------------------------
   // Predictor state. The recency order is held as a queue of keys, oldest
   // at the front, with a parallel queue of values. This is a different
   // structure from the slot-linked list in the block, but it yields the same
   // hits, values and victims.
   // ------------------------------------------------------------------------
   logic [63:0] lru_keys[$];
   logic [31:0] lru_values[$];
   int unsigned cap_setting;

   rsp_word_type pending_rsp[$];
   int           error_count;
   int           idle_cycles;
   bit           hold_rsp;        // long receiver hold-off in progress
   bit           rsp_busy_phase;  // phase with no random idling

   function automatic rsp_word_type cache_access(req_word_type w);
      rsp_word_type r;
      int           pos;
      int unsigned  limit;
      logic [31:0]  v;
      r   = '0;
      pos = -1;
      foreach (lru_keys[i]) begin
         if (lru_keys[i] == w.key) pos = i;
      end
      limit = (cap_setting == 0) ? 1 : ((cap_setting > DEPTH) ? DEPTH : cap_setting);
      if (pos >= 0) begin
         r.hit = 1'b1;
         v = lru_values[pos];
         if (w.command == CMD_GET) r.value_out = v;
         else v = w.value;
         lru_keys.delete(pos);
         lru_values.delete(pos);
         lru_keys.push_back(w.key);
         lru_values.push_back(v);
      end else if (w.command == CMD_PUT) begin
         if (lru_keys.size() >= limit) begin
            r.evicted     = 1'b1;
            r.evicted_key = lru_keys.pop_front();
            void'(lru_values.pop_front());
         end
         lru_keys.push_back(w.key);
         lru_values.push_back(w.value);
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Response side: sample at the rising edge, drive stall at the falling one.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected word", rsp_word.evicted_key, '0);
         end else begin
            rsp_word_type e;
            e = pending_rsp.pop_front();
            if (rsp_word.hit !== e.hit)
               report_mismatch("hit", 64'(rsp_word.hit), 64'(e.hit));
            if (rsp_word.value_out !== e.value_out)
               report_mismatch("value_out", 64'(rsp_word.value_out), 64'(e.value_out));
            if (rsp_word.evicted !== e.evicted)
               report_mismatch("evicted", 64'(rsp_word.evicted), 64'(e.evicted));
            if (rsp_word.evicted_key !== e.evicted_key)
               report_mismatch("evicted_key", rsp_word.evicted_key, e.evicted_key);
         end
      end
   end

   always @(negedge clock) begin
      if (hold_rsp) rsp_stall <= 1'b1;
      else if (rsp_busy_phase) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < 27);
   end

   // Watchdog: counts cycles in which neither channel moves a word, outside the long hold-off.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (hold_rsp) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // Send one request word and queue its predicted response at acceptance.
   // Valid stays high on return; the next word or a pause lowers it.
   task automatic send_word(req_word_type w, bit no_idle);
      if (!no_idle) begin
         while ($urandom_range(99) < 27) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_rsp.push_back(cache_access(w));
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic write_capacity(int unsigned c);
      drain_results();
      csr_write          <= 1'b1;
      csr_capacity_limit <= c[CAP_BITS-1:0];
      @(negedge clock);
      csr_write <= 1'b0;
      cap_setting = c[CAP_BITS-1:0];
   endtask

   // Pick a key from a small pool so that hits and evictions are frequent;
   // occasionally use a fully random key or an extreme one.
   function automatic logic [63:0] pick_key(int unsigned pool);
      int unsigned r;
      r = $urandom_range(99);
      if (r < 3) return 64'hFFFF_FFFF_FFFF_FFFF;
      if (r < 6) return '0;
      if (r < 12) return {$urandom, $urandom};
      return {32'hA5A5_0000, 32'($urandom_range(pool - 1))} ^ 64'h8000_0000_0000_0000;
   endfunction

   // Directed stimulus table; expected fields are given where they are
   // obvious, otherwise the predictor decides.
   typedef struct {
      req_word_type w;
      bit           typed;
      rsp_word_type want;
      int           cap;       // capacity written before this row, -1 none
   } row_type;

   row_type     dir_rows[$];
   rsp_word_type check_want;

   function automatic row_type mk(logic c, logic [63:0] k, logic [31:0] v, int cap,
                                  bit typed, logic h, logic [31:0] vo, logic ev,
                                  logic [63:0] ek);
      row_type r;
      r.w.command = c;  r.w.key = k;  r.w.value = v;
      r.cap = cap;  r.typed = typed;
      r.want.hit = h;  r.want.value_out = vo;  r.want.evicted = ev;
      r.want.evicted_key = ek;
      return r;
   endfunction

   initial begin
      req_word_type w;
      int unsigned  n;
      int unsigned  pool;
      logic [63:0]  kmax;
      int unsigned  caps[7];
      kmax               = '1;
      caps               = '{3, 1, 16, 512, 5, 0, 40};
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_word           = '0;
      rsp_stall          = 1'b0;
      csr_write          = 1'b0;
      csr_capacity_limit = '0;
      hold_rsp           = 1'b0;
      rsp_busy_phase     = 1'b0;
      error_count        = 0;
      cap_setting        = CAP_RESET;

      // Directed rows: empty cache after reset, extremes of key and value,
      // update of a present key, capacity zero acting as one, capacity one
      // replacing its single entry, and capacity lowered below the count.
      dir_rows.push_back(mk(CMD_GET, '0, '0, -1, 1, 0, 0, 0, 0));
      dir_rows.push_back(mk(CMD_PUT, '0, '1, -1, 1, 0, 0, 0, 0));
      dir_rows.push_back(mk(CMD_GET, '0, '0, -1, 1, 1, 32'hFFFF_FFFF, 0, 0));
      dir_rows.push_back(mk(CMD_PUT, kmax, '0, -1, 1, 0, 0, 0, 0));
      dir_rows.push_back(mk(CMD_PUT, kmax, 32'h0A00_0001, -1, 1, 1, 0, 0, 0));
      dir_rows.push_back(mk(CMD_GET, kmax, '0, -1, 1, 1, 32'h0A00_0001, 0, 0));
      dir_rows.push_back(mk(CMD_PUT, 64'h5555_5555_5555_5555, 32'h5555_5555, -1, 0,
                            0, 0, 0, 0));
      dir_rows.push_back(mk(CMD_PUT, 64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA, -1, 0,
                            0, 0, 0, 0));
      dir_rows.push_back(mk(CMD_GET, '0, '0, -1, 0, 0, 0, 0, 0));
      // Capacity two while four entries are held: each insert evicts one.
      dir_rows.push_back(mk(CMD_PUT, 64'h1, 32'h1, 2, 0, 0, 0, 0, 0));
      dir_rows.push_back(mk(CMD_PUT, 64'h2, 32'h2, -1, 0, 0, 0, 0, 0));
      dir_rows.push_back(mk(CMD_GET, 64'h1, '0, -1, 0, 0, 0, 0, 0));
      dir_rows.push_back(mk(CMD_PUT, 64'h3, 32'h3, -1, 0, 0, 0, 0, 0));
      // Capacity zero is treated as one.
      dir_rows.push_back(mk(CMD_PUT, 64'h4, 32'h4, 0, 0, 0, 0, 0, 0));
      dir_rows.push_back(mk(CMD_PUT, 64'h5, 32'h5, -1, 0, 0, 0, 0, 0));
      dir_rows.push_back(mk(CMD_PUT, 64'h6, 32'h6, 1, 0, 0, 0, 0, 0));
      dir_rows.push_back(mk(CMD_GET, 64'h6, '0, -1, 0, 0, 0, 0, 0));
      dir_rows.push_back(mk(CMD_PUT, 64'h6, 32'h66, -1, 0, 0, 0, 0, 0));
      dir_rows.push_back(mk(CMD_GET, 64'h5, '0, -1, 0, 0, 0, 0, 0));
      // Capacity above the depth saturates.
      dir_rows.push_back(mk(CMD_PUT, 64'h7, 32'h7, 1023, 0, 0, 0, 0, 0));
      dir_rows.push_back(mk(CMD_GET, 64'h6, '0, -1, 0, 0, 0, 0, 0));

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // The typed rows are cross-checked against the predictor as they go.
      foreach (dir_rows[i]) begin
         if (dir_rows[i].cap >= 0) write_capacity(dir_rows[i].cap);
         send_word(dir_rows[i].w, 1'b0);
         if (dir_rows[i].typed) begin
            check_want = pending_rsp[$];
            if (check_want !== dir_rows[i].want)
               report_mismatch("directed row", check_want.evicted_key,
                               dir_rows[i].want.evicted_key);
            pending_rsp[$] = dir_rows[i].want;
         end
      end

      // Random phases over several capacities; small pools around the limit
      // keep hits, updates and evictions all common.
      foreach (caps[p]) begin
         write_capacity(caps[p]);
         pool = (caps[p] == 512) ? 600 : caps[p] * 2 + 2;
         n    = (caps[p] == 512) ? 220 : 150;
         rsp_busy_phase = (p == 2);
         for (int k = 0; k < n; k++) begin
            w.command = ($urandom_range(99) < 55) ? CMD_PUT : CMD_GET;
            w.key     = pick_key(pool);
            w.value   = $urandom;
            send_word(w, p == 2);
            // Long receiver hold-off while the sender keeps offering words.
            if (p == 3 && k == 20) begin
               fork
                  begin
                     hold_rsp = 1'b1;
                     repeat (HOLD_CYCLES) @(negedge clock);
                     hold_rsp = 1'b0;
                  end
               join_none
            end
            // Sender pause until everything has come back.
            if (k == 60) begin
               req_valid <= 1'b0;
               while (pending_rsp.size() != 0) @(negedge clock);
            end
         end
      end
      rsp_busy_phase = 1'b0;

      drain_results();
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/lkvc_pkg.sv
rtl/lru_key_value_cache_core.sv
sim/tb_lru_key_value_cache_core.sv
